// ----- hw/rtl/evkbc_pkg.sv -----
// Package for the evolving-key byte cipher: key size, base key table,
// seed-mix constants and the shared item and key types.
// No dependencies.
package evkbc_pkg;

  localparam int unsigned KeyLen   = 16;
  localparam int unsigned KeyIdxW  = $clog2(KeyLen);
  localparam int unsigned MixCount = 14;

  localparam logic [7:0] KeyMask = 8'h7f;
  localparam logic [7:0] MixA    = 8'h80;
  localparam logic [7:0] MixB    = 8'h02;

  // Function select carried in tuser bit 0
  typedef enum logic {
    FUNC_DECRYPT = 1'b0,
    FUNC_ENCRYPT = 1'b1
  } func_e;

  typedef logic [KeyLen-1:0][7:0] key_arr_t;

  // Base key table, entry 0 in the lowest byte
  localparam key_arr_t BaseTable = {
    8'h7f, 8'h5e, 8'h3b, 8'h2d, 8'h30, 8'h33, 8'h5f, 8'h2c,
    8'h36, 8'h5f, 8'h2c, 8'h2a, 8'h2c, 8'h3a, 8'h35, 8'h5f
  };

  // Key after reset and the starting point of a rebuild
  function automatic key_arr_t base_key();
    key_arr_t k;
    for (int unsigned n = 0; n < KeyLen; n++) begin
      k[n] = BaseTable[n] ^ KeyMask;
    end
    return k;
  endfunction

  // One input item as held in the input register
  typedef struct packed {
    func_e       func;
    logic        start_req;
    logic [7:0]  seed_a;
    logic [15:0] seed_b;
    logic [7:0]  data_in;
    logic        last;
  } item_t;

endpackage

// ----- hw/rtl/evolving_key_byte_cipher.sv -----
// Top level of the evolving-key byte cipher: stream ports, input and
// result registers, key and index state. Depends on evkbc_pkg, evkbc_core.
//
// Byte stream cipher with a 16-byte key that changes after every byte.
// One byte is accepted per clock while results are taken, and its result is
// offered after the input register, then the result register; throughput is
// one byte per cycle as long as the output side takes results. A byte with
// start_req set (tuser bit 1) rebuilds the key from seed_a/seed_b and
// restarts the index before it is processed; tuser bit 0 selects encrypt (1)
// or decrypt (0). The key lives in flip-flops and every byte reads three
// entries and rewrites two in the single transform stage. tlast is echoed
// unchanged.
module evolving_key_byte_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // seed_a[7:0], seed_b[23:8], data_in[31:24]
  input  logic [1:0]  s_axis_tuser,  // func[0], start_req[1]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // data_out[7:0]
  output logic        m_axis_tlast
);
  import evkbc_pkg::*;

  logic       in_valid_q;
  item_t      in_item_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_last_q;
  key_arr_t   key_q, key_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] res_data;
  logic       out_free;
  logic       adv;
  logic       in_xfer;

  // Result register frees when empty or when its transfer completes
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  evkbc_core u_core (
    .item_i (in_item_q),
    .key_i  (key_q),
    .idx_i  (idx_q),
    .data_o (res_data),
    .key_o  (key_d),
    .idx_o  (idx_d)
  );

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.func      <= func_e'(s_axis_tuser[0]);
      in_item_q.start_req <= s_axis_tuser[1];
      in_item_q.seed_a    <= s_axis_tdata[7:0];
      in_item_q.seed_b    <= s_axis_tdata[23:8];
      in_item_q.data_in   <= s_axis_tdata[31:24];
      in_item_q.last      <= s_axis_tlast;
    end
  end

  // Key and index advance once per byte moved to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= base_key();
      idx_q <= 8'd0;
    end else if (adv) begin
      key_q <= key_d;
      idx_q <= idx_d;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= res_data;
      out_last_q <= in_item_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // A start byte leaves the index at one
  a_start_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_item_q.start_req |=> idx_q == 8'd1)
    else $error("index not restarted by start byte");

  // Every other byte advances the index by one
  a_idx_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_item_q.start_req |=> idx_q == $past(idx_q) + 8'd1)
    else $error("index did not advance");

  // Key holds while no byte moves forward
  a_key_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(key_q) && $stable(idx_q))
    else $error("key changed without a byte");

endmodule

// ----- hw/rtl/evkbc_core.sv -----
// Byte transform of the evolving-key cipher: seed mix on start, key
// select, encrypt/decrypt arithmetic and the next key and index.
// Depends on evkbc_pkg.
module evkbc_core (
  input  evkbc_pkg::item_t    item_i,
  input  evkbc_pkg::key_arr_t key_i,
  input  logic [7:0]          idx_i,
  output logic [7:0]          data_o,
  output evkbc_pkg::key_arr_t key_o,
  output logic [7:0]          idx_o
);
  import evkbc_pkg::*;

  logic [15:0]        sb_eff;
  logic [7:0]         mix_a;
  logic [7:0]         mix_b;
  key_arr_t           key_mixed;
  key_arr_t           key_eff;
  logic [7:0]         idx_eff;
  logic [KeyIdxW-1:0] p0, p1, p2;
  logic [7:0]         k0, k1, k2;
  logic [7:0]         cipher;

  // Build the seeded key; encrypt takes the sign-extended low seed byte
  always_comb begin
    key_arr_t base;
    base   = base_key();
    sb_eff = (item_i.func == FUNC_ENCRYPT) ?
             {{8{item_i.seed_b[7]}}, item_i.seed_b[7:0]} : item_i.seed_b;
    mix_a  = (sb_eff[14:7] + item_i.seed_a) ^ MixA;
    mix_b  = (sb_eff[7:0] - item_i.seed_a) ^ MixB;
    for (int unsigned n = 0; n < KeyLen; n++) begin
      if (n >= MixCount) begin
        key_mixed[n] = base[n];
      end else if (n % 2 == 0) begin
        key_mixed[n] = mix_b ^ (mix_a + base[n]);
      end else begin
        key_mixed[n] = mix_a ^ (base[n] - mix_b);
      end
    end
  end

  assign key_eff = item_i.start_req ? key_mixed : key_i;
  assign idx_eff = item_i.start_req ? 8'd0 : idx_i;

  // Key positions wrap around the key length
  assign p0 = idx_eff[KeyIdxW-1:0];
  assign p1 = p0 + KeyIdxW'(1);
  assign p2 = p0 + KeyIdxW'(2);
  assign k0 = key_eff[p0];
  assign k1 = key_eff[p1];
  assign k2 = key_eff[p2];

  // Transform the byte and pick the ciphertext side for key feedback
  always_comb begin
    unique case (item_i.func)
      FUNC_ENCRYPT: begin
        data_o = ((item_i.data_in + k0) - k1) ^ k2;
        cipher = data_o;
      end
      FUNC_DECRYPT: begin
        data_o = ((item_i.data_in ^ k2) + k1) - k0;
        cipher = item_i.data_in;
      end
      default: begin
        data_o = item_i.data_in;
        cipher = item_i.data_in;
      end
    endcase
  end

  // Evolve two key bytes and advance the index
  always_comb begin
    key_o     = key_eff;
    key_o[p1] = k1 ^ cipher;
    key_o[p2] = k2 ^ idx_eff;
  end

  assign idx_o = idx_eff + 8'd1;

endmodule

// ----- bench/evolving_key_byte_cipher_tb.sv -----
// Testbench for evolving_key_byte_cipher: streams directed and random byte strings,
// predicts every output byte with an independent key model and checks it in order.
// Depends on evkbc_pkg and the evolving_key_byte_cipher RTL.
`timescale 1ns / 100ps

module evolving_key_byte_cipher_tb;
  import evkbc_pkg::*;

  localparam int unsigned RandomBytes = 1400;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;

  // Reset key source, entry 0 first
  localparam logic [7:0] KeyBase [KeyLen] = '{
    8'h5f, 8'h35, 8'h3a, 8'h2c, 8'h2a, 8'h2c, 8'h5f, 8'h36,
    8'h2c, 8'h5f, 8'h33, 8'h30, 8'h2d, 8'h3b, 8'h5e, 8'h7f
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  // Key model plus in-order queue of predicted output bytes
  class cipher_scoreboard;
    logic [7:0]  key_q [KeyLen];
    logic [7:0]  index_q;
    cipher_out_t expected_q [$];
    int unsigned fail_count;

    function new();
      reload_key();
      index_q    = '0;
      fail_count = 0;
    endfunction

    function void reload_key();
      for (int unsigned n = 0; n < KeyLen; n++) begin
        key_q[n] = KeyBase[n] ^ KeyMask;
      end
    endfunction

    // Rebuild the key from both seeds; encrypt takes seed_b's low byte sign-extended
    function void rekey(input item_t it);
      logic [15:0] sb;
      logic [7:0]  mix_a;
      logic [7:0]  mix_b;
      logic [7:0]  sum;
      sb = it.seed_b;
      if (it.func == FUNC_ENCRYPT) begin
        sb = {{8{it.seed_b[7]}}, it.seed_b[7:0]};
      end
      reload_key();
      mix_a = (sb[14:7] + it.seed_a) ^ MixA;
      mix_b = (sb[7:0] - it.seed_a) ^ MixB;
      for (int unsigned n = 0; n < MixCount; n++) begin
        if (n % 2 == 0) begin
          sum      = mix_a + key_q[n];
          key_q[n] = mix_b ^ sum;
        end else begin
          sum      = key_q[n] - mix_b;
          key_q[n] = mix_a ^ sum;
        end
      end
      index_q = '0;
    endfunction

    // Transform one byte and evolve the key behind it
    function logic [7:0] cipher_byte(input item_t it);
      logic [3:0] p0;
      logic [3:0] p1;
      logic [3:0] p2;
      logic [7:0] k0;
      logic [7:0] k1;
      logic [7:0] k2;
      logic [7:0] acc;
      logic [7:0] ctext;
      p0 = index_q[3:0];
      p1 = p0 + 4'd1;
      p2 = p0 + 4'd2;
      k0 = key_q[p0];
      k1 = key_q[p1];
      k2 = key_q[p2];
      if (it.func == FUNC_ENCRYPT) begin
        acc   = it.data_in + k0;
        acc   = acc - k1;
        acc   = acc ^ k2;
        ctext = acc;
      end else begin
        acc   = it.data_in ^ k2;
        acc   = acc + k1;
        acc   = acc - k0;
        ctext = it.data_in;
      end
      key_q[p1] = k1 ^ ctext;
      key_q[p2] = k2 ^ index_q;
      index_q   = index_q + 8'd1;
      return acc;
    endfunction

    function void note_input(input item_t it);
      cipher_out_t exp_out;
      if (it.start_req) begin
        rekey(it);
      end
      exp_out.data = cipher_byte(it);
      exp_out.last = it.last;
      expected_q.push_back(exp_out);
    endfunction

    function void check_result(input logic [7:0] data, input logic last);
      cipher_out_t exp_out;
      if (expected_q.size() == 0) begin
        $error("output byte 0x%02h with no prediction pending", data);
        fail_count++;
        return;
      end
      exp_out = expected_q.pop_front();
      if (data !== exp_out.data) begin
        $error("data_out: expected 0x%02h, actual 0x%02h", exp_out.data, data);
        fail_count++;
      end
      if (last !== exp_out.last) begin
        $error("last_out: expected %0b, actual %0b", exp_out.last, last);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // seed_a[7:0], seed_b[23:8], data_in[31:24]
  logic [1:0]  s_axis_tuser  = '0;  // func[0], start_req[1]
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // data_out[7:0]
  logic        m_axis_tlast;

  cipher_scoreboard sb = new();

  int unsigned cycle_cnt   = 0;
  int unsigned burst_left  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;

  evolving_key_byte_cipher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Predict on every input transfer
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      it.func      = s_axis_tuser[0] ? FUNC_ENCRYPT : FUNC_DECRYPT;
      it.start_req = s_axis_tuser[1];
      it.seed_a    = s_axis_tdata[7:0];
      it.seed_b    = s_axis_tdata[23:8];
      it.data_in   = s_axis_tdata[31:24];
      it.last      = s_axis_tlast;
      sb.note_input(it);
    end
  end

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // Receiver backpressure: switch between free-running, coin-flip, heavy and periodic
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (cycle_cnt % 7 < 4);
    endcase
  end

  function automatic item_t make_byte(input func_e f, input logic st, input logic [7:0] sa,
                                      input logic [15:0] sbv, input logic [7:0] d,
                                      input logic lst);
    item_t it;
    it.func      = f;
    it.start_req = st;
    it.seed_a    = sa;
    it.seed_b    = sbv;
    it.data_in   = d;
    it.last      = lst;
    return it;
  endfunction

  // Present one byte, in bursts with random gaps, and hold until it transfers
  task automatic send_byte(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.data_in, it.seed_b, it.seed_a};
    s_axis_tuser  <= {it.start_req, it.func};
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    bytes_sent++;
  endtask

  // One string with random content; malformed strings get stray starts and last flags
  task automatic send_string(input int unsigned len, input bit well_formed);
    func_e f;
    bit    mixed;
    item_t it;
    f     = $urandom_range(0, 1) ? FUNC_ENCRYPT : FUNC_DECRYPT;
    mixed = ($urandom_range(0, 9) == 0);
    for (int unsigned n = 0; n < len; n++) begin
      it.func    = f;
      if (mixed) begin
        it.func = $urandom_range(0, 1) ? FUNC_ENCRYPT : FUNC_DECRYPT;
      end
      it.seed_a  = 8'($urandom);
      it.seed_b  = 16'($urandom);
      it.data_in = 8'($urandom);
      if (well_formed) begin
        it.start_req = (n == 0);
        it.last      = (n == len - 1);
      end else begin
        it.start_req = ($urandom_range(0, 7) == 0);
        it.last      = 1'($urandom_range(0, 1));
      end
      send_byte(it);
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned strings_sent;
    int unsigned long_strings;
    strings_sent = 0;
    long_strings = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes before any start run on the reset key
    send_byte(make_byte(FUNC_DECRYPT, 1'b0, 8'h00, 16'h0000, 8'h00, 1'b0));
    send_byte(make_byte(FUNC_ENCRYPT, 1'b0, 8'hff, 16'hffff, 8'hff, 1'b1));
    // Seed extremes, both directions
    send_byte(make_byte(FUNC_DECRYPT, 1'b1, 8'h00, 16'h0000, 8'h00, 1'b0));
    send_byte(make_byte(FUNC_DECRYPT, 1'b0, 8'h00, 16'h0000, 8'hff, 1'b0));
    send_byte(make_byte(FUNC_ENCRYPT, 1'b0, 8'h00, 16'h0000, 8'h00, 1'b1));
    send_byte(make_byte(FUNC_DECRYPT, 1'b1, 8'hff, 16'hffff, 8'h5a, 1'b0));
    send_byte(make_byte(FUNC_ENCRYPT, 1'b0, 8'h00, 16'h0000, 8'ha5, 1'b1));
    // Encrypt start: negative low seed byte sign-extends, high byte ignored
    send_byte(make_byte(FUNC_ENCRYPT, 1'b1, 8'h80, 16'h0080, 8'hff, 1'b0));
    send_byte(make_byte(FUNC_DECRYPT, 1'b0, 8'h00, 16'h0000, 8'h00, 1'b1));
    send_byte(make_byte(FUNC_ENCRYPT, 1'b1, 8'h7f, 16'hff7f, 8'h01, 1'b1));
    send_byte(make_byte(FUNC_ENCRYPT, 1'b1, 8'h00, 16'h7fff, 8'h80, 1'b0));
    send_byte(make_byte(FUNC_ENCRYPT, 1'b0, 8'h00, 16'h0000, 8'h7f, 1'b1));
    // Decrypt start uses seed_b bits 14:0; bit 15 does not enter the mix
    send_byte(make_byte(FUNC_DECRYPT, 1'b1, 8'h01, 16'h8000, 8'h80, 1'b0));
    send_byte(make_byte(FUNC_DECRYPT, 1'b1, 8'h55, 16'haaaa, 8'h33, 1'b1));
    // Start and last on the same byte, then restart mid-string
    send_byte(make_byte(FUNC_ENCRYPT, 1'b1, 8'haa, 16'h5555, 8'hcc, 1'b1));
    send_byte(make_byte(FUNC_DECRYPT, 1'b0, 8'h12, 16'h3456, 8'h78, 1'b0));
    send_byte(make_byte(FUNC_ENCRYPT, 1'b1, 8'hfe, 16'h01fe, 8'hfe, 1'b0));
    send_byte(make_byte(FUNC_DECRYPT, 1'b0, 8'h00, 16'h0000, 8'h01, 1'b1));

    // Random strings; a few long ones wrap the byte index past 255
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      if (strings_sent == 4 || (long_strings < 2 && $urandom_range(0, 39) == 0)) begin
        len = $urandom_range(260, 300);
        long_strings++;
      end else begin
        len = $urandom_range(1, 40);
      end
      send_string(len, $urandom_range(0, 99) < 85);
      strings_sent++;
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
